@@ sv/mrt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrt_pkg
// Request, response, table entry and state types used by masked_route_table.
// ----------------------------------------------------------------------------
package mrt_pkg;

   // Width of a stored device number
   localparam int DEV_W = 4;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_ADD    = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_FLUSH  = 2'd3
   } req_kind_type;

   // One request item
   typedef struct packed {
      req_kind_type      req_type;
      logic [31:0]       dest_addr;
      logic [31:0]       net_mask;
      logic [31:0]       gateway_addr;
      logic [DEV_W-1:0]  device_id;
      logic              permanent;
   } req_item_type;

   // One response item
   typedef struct packed {
      logic              success;
      logic [DEV_W-1:0]  out_device;
      logic [31:0]       out_gateway;
   } rsp_item_type;

   // One table slot as held in the RAM
   typedef struct packed {
      logic              valid;
      logic              perm;
      logic [31:0]       network;
      logic [31:0]       mask;
      logic [31:0]       gateway;
      logic [DEV_W-1:0]  device;
   } entry_type;

   // Controller states, one-hot
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

endpackage

@@ sv/mrt_ram.sv @@
// ----------------------------------------------------------------------------
// mrt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/masked_route_table.sv @@
// ----------------------------------------------------------------------------
// masked_route_table
// First-match IPv4 route table held in one RAM, scanned one slot per cycle.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one response, shown on rsp_data for a single cycle with rsp_strobe
// high; the receiver cannot stall it. All slots live in one RAM with a
// registered read port, and each request walks the slots from slot 0 upward
// at one read per cycle: lookup, remove and add stop at the first matching or
// free slot, flush always walks all ENTRIES slots. An add with a device number
// not below DEVICES is answered with success low without a walk. The next
// request may start in the cycle the response is shown. After reset the
// block clears all ENTRIES slots with busy high.
module masked_route_table #(
   parameter int ENTRIES = 16,
   parameter int DEVICES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mrt_pkg::req_item_type req_data,
   output logic                  rsp_strobe,
   output mrt_pkg::rsp_item_type rsp_data
);
   import mrt_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int EW = $bits(entry_type);

   state_type     state_ff, state_in;
   logic [CW-1:0] scan_addr_ff, scan_addr_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [AW-1:0] chk_addr_ff, chk_addr_in;
   req_item_type  req_ff, req_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type  rsp_data_ff, rsp_data_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_entry;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_word;
   entry_type     rd_entry;

   logic          issue;
   logic          last_chk;
   logic          addr_hit;
   logic          stop;
   logic          accept;

   // Table storage
   mrt_ram #(
      .WIDTH (EW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry = entry_type'(rd_word);
   assign accept   = start && (state_ff == ST_IDLE);
   assign issue    = (state_ff == ST_SCAN) && (scan_addr_ff < CW'(ENTRIES));
   assign rd_addr  = issue ? scan_addr_ff[AW-1:0] : '0;
   assign last_chk = chk_addr_ff == AW'(ENTRIES - 1);
   assign addr_hit = rd_entry.valid &&
                     (rd_entry.network == (req_ff.dest_addr & rd_entry.mask));

   // Decide whether the slot on the read port ends the walk
   always_comb begin
      case (req_ff.req_type)
         REQ_LOOKUP, REQ_REMOVE: stop = addr_hit;
         REQ_ADD:                stop = !rd_entry.valid;
         default:                stop = 1'b0;
      endcase
   end

   // Sequencer: clear pass, request accept, slot walk
   always_comb begin
      state_in      = state_ff;
      scan_addr_in  = scan_addr_ff;
      chk_vld_in    = 1'b0;
      chk_addr_in   = chk_addr_ff;
      req_in        = req_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_addr_ff;
      wr_entry      = '0;

      case (state_ff)
         ST_CLEAR: begin
            // Zero one slot per cycle
            wr_en        = 1'b1;
            wr_addr      = scan_addr_ff[AW-1:0];
            scan_addr_in = scan_addr_ff + CW'(1);
            if (scan_addr_ff == CW'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in       = req_data;
               scan_addr_in = '0;
               if (req_data.req_type == REQ_ADD &&
                   !(32'(req_data.device_id) < DEVICES)) begin
                  // Reject unknown device at once
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Advance the read pointer
            chk_vld_in  = issue;
            chk_addr_in = scan_addr_ff[AW-1:0];
            if (issue) begin
               scan_addr_in = scan_addr_ff + CW'(1);
            end
            if (chk_vld_ff) begin
               if (stop) begin
                  rsp_strobe_in       = 1'b1;
                  rsp_data_in         = '0;
                  rsp_data_in.success = 1'b1;
                  chk_vld_in          = 1'b0;
                  state_in            = ST_IDLE;
                  if (req_ff.req_type == REQ_LOOKUP) begin
                     rsp_data_in.out_device  = rd_entry.device;
                     rsp_data_in.out_gateway = rd_entry.gateway;
                  end else if (req_ff.req_type == REQ_REMOVE) begin
                     wr_en = 1'b1;
                  end else begin
                     // Store the new route in the free slot
                     wr_en            = 1'b1;
                     wr_entry.valid   = 1'b1;
                     wr_entry.perm    = req_ff.permanent;
                     wr_entry.network = req_ff.dest_addr & req_ff.net_mask;
                     wr_entry.mask    = req_ff.net_mask;
                     wr_entry.gateway = req_ff.gateway_addr;
                     wr_entry.device  = req_ff.device_id;
                  end
               end else begin
                  // Drop non-permanent routes during a flush
                  if (req_ff.req_type == REQ_FLUSH &&
                      rd_entry.valid && !rd_entry.perm) begin
                     wr_en = 1'b1;
                  end
                  if (last_chk) begin
                     rsp_strobe_in       = 1'b1;
                     rsp_data_in         = '0;
                     rsp_data_in.success = (req_ff.req_type == REQ_FLUSH);
                     chk_vld_in          = 1'b0;
                     state_in            = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         scan_addr_ff  <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_addr_ff  <= scan_addr_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chk_addr_ff <= chk_addr_in;
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   // A slot check is only pending while walking
   a_chk_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> state_ff == ST_SCAN)
      else $error("slot check pending outside of a walk");

   // The table is never written while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !wr_en)
      else $error("table written while idle");

   // Every walk ends with a response
   a_walk_responds: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && $past(state_ff == ST_SCAN) |-> rsp_strobe)
      else $error("walk ended without a response");

   // A response follows a walk or an accepted item
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_SCAN || (start && !busy)))
      else $error("response without a request");
`endif

endmodule
